// File: sv/assert_macros.svh
// Assertion macros shared by the sorted sparse array table RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check that a condition holds at every clock edge outside reset.
`define SSAT_ASSERT(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
// Check that a condition implies a consequence at the following clock edge.
`define SSAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SSAT_ASSERT(label, clk, rst_n, cond)
`define SSAT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/ssat_pkg.sv
// Types and constants of the sorted sparse array table.
// No dependencies; used by ssat_cell and sorted_sparse_array_table_core.
package ssat_pkg;

    // Operation codes.
    localparam logic [1:0] OP_READ   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_EXISTS = 2'd2;

    // Field widths.
    localparam int KEY_W   = 32;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 7;

    // Input word.
    typedef struct packed {
        logic [1:0]               operation;
        logic signed [KEY_W-1:0]  index;
        logic signed [DATA_W-1:0] write_value;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic                     was_present;
        logic [COUNT_W-1:0]       entry_count;
        logic                     table_full_error;
    } out_word_t;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        logic                     apply;
        logic                     insert;
        logic                     write;
        logic signed [KEY_W-1:0]  key;
        logic signed [DATA_W-1:0] wval;
        logic signed [DATA_W-1:0] fill;
    } cell_cmd_t;

endpackage

// File: sv/sorted_sparse_array_table_core.sv
// Sorted sparse array table: top level with a row of entry cells.
// Depends on ssat_pkg, ssat_cell and assert_macros.svh.
//
// Usage: words enter on the in channel (in_valid, in_ready, in_data) and
// results leave on the out channel (out_valid, out_ready, out_data), one
// result word for every input word, in order. A read of an absent index
// inserts it with the default fill value; a write finds or inserts it and
// stores write_value; neither inserts into a full table. An exists query
// changes nothing. The default fill value is written over the cfg channel
// (cfg_valid, cfg_ready, cfg_data); cfg_ready is always high. The user
// must write it while the block is idle; the block itself does not enforce
// it. The accepting edge loads the request register; every cell compares
// the key against its entry and the row shifts to insert at the edge that
// loads the result register. Throughput is one word per cycle while the
// receiver does not stall, set by the single compare-and-shift pass over
// the cell row. Reset empties the table and clears the default fill value
// to zero. When the receiver stalls, the result register holds, the
// request register fills, and then in_ready drops until out_ready returns.
`include "assert_macros.svh"

module sorted_sparse_array_table_core #(
    parameter int CAPACITY = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  ssat_pkg::in_word_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output ssat_pkg::out_word_t                 out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic signed [ssat_pkg::DATA_W-1:0]  cfg_data
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic                               req_valid_reg;
    ssat_pkg::in_word_t                 req_reg;
    logic                               out_valid_reg;
    ssat_pkg::out_word_t                out_reg;
    ssat_pkg::out_word_t                out_next;
    logic [CW-1:0]                      count_reg;
    logic [CW-1:0]                      count_next;
    logic signed [ssat_pkg::DATA_W-1:0] fill_reg;

    logic                               proc;
    logic                               is_rd;
    logic                               is_wr;
    logic                               full;
    logic                               present;
    logic                               need_ins;
    logic                               do_ins;
    logic                               err;
    logic signed [ssat_pkg::DATA_W-1:0] hit_data;
    ssat_pkg::cell_cmd_t                cmd;

    logic                               less_w [CAPACITY];
    logic                               hit_w  [CAPACITY];
    logic signed [ssat_pkg::KEY_W-1:0]  key_w  [CAPACITY];
    logic signed [ssat_pkg::DATA_W-1:0] data_w [CAPACITY];

    // Handshakes.
    assign proc      = req_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !req_valid_reg || proc;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;

    // Operation decode and insert decision.
    assign is_rd    = req_reg.operation == ssat_pkg::OP_READ;
    assign is_wr    = req_reg.operation == ssat_pkg::OP_WRITE;
    assign full     = count_reg == CW'(CAPACITY);
    assign need_ins = (is_rd || is_wr) && !present;
    assign do_ins   = need_ins && !full;
    assign err      = need_ins && full;

    // Command broadcast to the row.
    always_comb
    begin
        cmd.apply  = proc;
        cmd.insert = do_ins;
        cmd.write  = is_wr;
        cmd.key    = req_reg.index;
        cmd.wval   = req_reg.write_value;
        cmd.fill   = fill_reg;
    end

    // The row of cells, each handing its entry to its right neighbor.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                               l_less;
        logic signed [ssat_pkg::KEY_W-1:0]  l_key;
        logic signed [ssat_pkg::DATA_W-1:0] l_data;

        if (i == 0)
        begin : g_first
            assign l_less = 1'b1;
            assign l_key  = '0;
            assign l_data = '0;
        end
        else
        begin : g_rest
            assign l_less = less_w[i-1];
            assign l_key  = key_w[i-1];
            assign l_data = data_w[i-1];
        end

        ssat_cell u_cell (
            .clk       (clk),
            .occupied  (CW'(i) < count_reg),
            .cmd       (cmd),
            .left_less (l_less),
            .left_key  (l_key),
            .left_data (l_data),
            .less      (less_w[i]),
            .hit       (hit_w[i]),
            .key       (key_w[i]),
            .data      (data_w[i])
        );
    end

    // Gather the matching entry; at most one cell hits.
    always_comb
    begin
        present  = 1'b0;
        hit_data = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            present  = present | hit_w[i];
            hit_data = hit_data | (data_w[i] & {ssat_pkg::DATA_W{hit_w[i]}});
        end
    end

    // Result word.
    always_comb
    begin
        count_next = count_reg + CW'(do_ins);
        out_next.was_present      = present;
        out_next.entry_count      = ssat_pkg::COUNT_W'(count_next);
        out_next.table_full_error = err;
        if (!(is_rd || is_wr))
            out_next.read_value = '0;
        else if (err)
            out_next.read_value = fill_reg;
        else if (is_wr)
            out_next.read_value = req_reg.write_value;
        else if (present)
            out_next.read_value = hit_data;
        else
            out_next.read_value = fill_reg;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            fill_reg      <= '0;
        end
        else
        begin
            if (in_ready)
                req_valid_reg <= in_valid;
            if (proc)
            begin
                out_valid_reg <= 1'b1;
                count_reg     <= count_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid)
                fill_reg <= cfg_data;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            req_reg <= in_data;
        if (proc)
            out_reg <= out_next;
    end

    // Assertions.
    `SSAT_ASSERT(a_count_bound, clk, rst_n, count_reg <= CW'(CAPACITY))
    `SSAT_ASSERT_NEXT(a_err_keeps_count, clk, rst_n, proc && err, $stable(count_reg))
    `SSAT_ASSERT_NEXT(a_insert_grows, clk, rst_n, proc && do_ins, count_reg == $past(count_reg) + CW'(1))
    `SSAT_ASSERT(a_sorted_head, clk, rst_n, (count_reg < CW'(2)) || (key_w[0] < key_w[1]))
    `SSAT_ASSERT(a_err_only_full, clk, rst_n, !(proc && err) || full)

endmodule

// File: sv/ssat_cell.sv
// One cell of the sorted entry row: holds one (index, value) entry.
// Depends on ssat_pkg for the command type and widths.
module ssat_cell (
    input  logic                                 clk,
    input  logic                                 occupied,
    input  ssat_pkg::cell_cmd_t                  cmd,
    input  logic                                 left_less,
    input  logic signed [ssat_pkg::KEY_W-1:0]    left_key,
    input  logic signed [ssat_pkg::DATA_W-1:0]   left_data,
    output logic                                 less,
    output logic                                 hit,
    output logic signed [ssat_pkg::KEY_W-1:0]    key,
    output logic signed [ssat_pkg::DATA_W-1:0]   data
);

    logic signed [ssat_pkg::KEY_W-1:0]  key_reg;
    logic signed [ssat_pkg::DATA_W-1:0] data_reg;
    logic                               at_pos;
    logic                               shift;

    // Compare the stored entry against the broadcast key.
    assign less   = occupied && (key_reg < cmd.key);
    assign hit    = occupied && (key_reg == cmd.key);
    assign at_pos = !less && left_less;
    assign shift  = !left_less;
    assign key    = key_reg;
    assign data   = data_reg;

    // Take the new entry, take the left neighbor's entry, or update in place.
    always_ff @(posedge clk)
    begin
        if (cmd.apply)
        begin
            if (cmd.insert)
            begin
                if (at_pos)
                begin
                    key_reg  <= cmd.key;
                    data_reg <= cmd.write ? cmd.wval : cmd.fill;
                end
                else if (shift)
                begin
                    key_reg  <= left_key;
                    data_reg <= left_data;
                end
            end
            else if (cmd.write && hit)
            begin
                data_reg <= cmd.wval;
            end
        end
    end

endmodule
